// ----- sv/rvp_pkg.sv -----
package rvp_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_SSRC,
    PH_CSRC,
    PH_PAYHDR,
    PH_LEN,
    PH_SKIP,
    PH_TRAIL
  } phase_e;

  typedef enum logic [2:0] {
    KIND_RTP     = 3'd0,
    KIND_SSRC    = 3'd1,
    KIND_CSRC    = 3'd2,
    KIND_PAYHDR  = 3'd3,
    KIND_BLKLEN  = 3'd4,
    KIND_FRAGLEN = 3'd5,
    KIND_END     = 3'd6,
    KIND_OVF     = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_t;

  typedef struct packed {
    kind_e       record_kind;
    logic [1:0]  version;
    logic        padding;
    logic        extension;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_res;
    logic [31:0] word;
    logic [1:0]  frag_type;
    logic [1:0]  data_type;
    logic [3:0]  count_or_index;
    logic        last_of_run;
  } rec_t;

  // up to two records per accepted byte, second only when the first is valid
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } qwr_t;

endpackage

// ----- sv/rtp_vorbis_payload_parser_unit.sv -----
// channel   dir  handshake           payload
// input     in   push / full         in_i  (data_byte, end_of_datagram)
// result    out  empty / pop         out_o (one record, twelve fields)
//
// each byte is parsed in the cycle it is accepted; its records reach the result
// side in the next cycle and leave via a four-entry queue at one record per cycle
// while pop is high; one byte per cycle is sustained while bytes cause one record
// each and pop keeps up; a byte that completes a record and ends a datagram queues
// two, so the pop side sets the rate then; full rises when fewer than two queue
// slots are free; reset clears parser state and queue at once, no clearing pass
module rtp_vorbis_payload_parser_unit #(
  parameter int unsigned MaxDatagram = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  rvp_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output rvp_pkg::rec_t out_o
);

  rvp_pkg::qwr_t qwr;
  logic          acc;

  assign acc = push && !full;

  rvp_front #(
    .MaxDatagram(MaxDatagram)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (acc),
    .in_i  (in_i),
    .qwr_o (qwr)
  );

  rvp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qwr_i  (qwr),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .rec_o  (out_o)
  );

`ifndef SYNTHESIS
  a_eod_queues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.end_of_datagram |=> !empty)
    else $error("end of datagram left no record");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qwr.v1 |-> qwr.v0)
    else $error("second record written without first");

  a_two_only_at_eod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qwr.v1 |-> acc && in_i.end_of_datagram)
    else $error("two records from a byte that does not end a datagram");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (out_o.record_kind == rvp_pkg::KIND_END ||
               out_o.record_kind == rvp_pkg::KIND_OVF) |-> out_o.last_of_run)
    else $error("end record not marked last");
`endif

endmodule

// ----- sv/rvp_front.sv -----
module rvp_front #(
  parameter int unsigned MaxDatagram = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  rvp_pkg::in_t  in_i,
  output rvp_pkg::qwr_t qwr_o
);

  localparam int unsigned CntW = $clog2(MaxDatagram);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxDatagram - 1);

  rvp_pkg::phase_e phase_q, phase_d, phase_nx;
  logic [3:0]      pos_q, pos_d;
  logic [31:0]     aw_q, aw_d;
  logic [15:0]     ftb_q, ftb_d;
  logic [15:0]     seq_q, seq_d;
  logic [3:0]      csrc_tot_q, csrc_tot_d;
  logic [3:0]      ii_q, ii_d;
  logic [3:0]      pkt_tot_q, pkt_tot_d;
  logic [15:0]     skip_q, skip_d;
  logic [CntW-1:0] unused_q, unused_d;

  logic [7:0]  b;
  logic        eod;
  logic [31:0] aw_sh;
  logic [15:0] len_val;
  logic [3:0]  ii_inc;
  logic [15:0] skip_dec;
  logic        fixed_done, word_done, len_done, parse_rec;
  rvp_pkg::rec_t prec, erec;

  assign b        = in_i.data_byte;
  assign eod      = in_i.end_of_datagram;
  assign aw_sh    = {aw_q[23:0], b};
  assign len_val  = {aw_q[7:0], b};
  assign ii_inc   = ii_q + 4'd1;
  assign skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;

  assign fixed_done = (phase_q == rvp_pkg::PH_FIXED) && (pos_q == 4'd7);
  assign word_done  = (phase_q inside {rvp_pkg::PH_SSRC, rvp_pkg::PH_CSRC,
                                       rvp_pkg::PH_PAYHDR}) && (pos_q == 4'd3);
  assign len_done   = (phase_q == rvp_pkg::PH_LEN) && (pos_q == 4'd1);
  assign parse_rec  = fixed_done || word_done || len_done;

  // parse step, then the end-of-datagram reset on top of it
  always_comb begin
    phase_nx   = phase_q;
    pos_d      = pos_q;
    aw_d       = aw_q;
    ftb_d      = ftb_q;
    seq_d      = seq_q;
    csrc_tot_d = csrc_tot_q;
    ii_d       = ii_q;
    pkt_tot_d  = pkt_tot_q;
    skip_d     = skip_q;
    unused_d   = unused_q;
    case (phase_q)
      rvp_pkg::PH_FIXED: begin
        if (pos_q < 4'd2) begin
          ftb_d = {ftb_q[7:0], b};
        end else if (pos_q < 4'd4) begin
          seq_d = {seq_q[7:0], b};
        end else begin
          aw_d = aw_sh;
        end
        pos_d = pos_q + 4'd1;
        if (fixed_done) begin
          csrc_tot_d = ftb_q[11:8];
          phase_nx   = rvp_pkg::PH_SSRC;
          pos_d      = '0;
          aw_d       = '0;
        end
      end
      rvp_pkg::PH_SSRC, rvp_pkg::PH_CSRC, rvp_pkg::PH_PAYHDR: begin
        aw_d  = aw_sh;
        pos_d = pos_q + 4'd1;
        if (word_done) begin
          pos_d = '0;
          aw_d  = '0;
          if (phase_q == rvp_pkg::PH_SSRC) begin
            ii_d     = '0;
            phase_nx = (csrc_tot_q != 4'd0) ? rvp_pkg::PH_CSRC : rvp_pkg::PH_PAYHDR;
          end else if (phase_q == rvp_pkg::PH_CSRC) begin
            ii_d     = ii_inc;
            phase_nx = (ii_inc >= csrc_tot_q) ? rvp_pkg::PH_PAYHDR : rvp_pkg::PH_CSRC;
          end else begin
            pkt_tot_d = b[3:0];
            ii_d      = '0;
            phase_nx  = rvp_pkg::PH_LEN;
          end
        end
      end
      rvp_pkg::PH_LEN: begin
        aw_d  = {16'd0, len_val};
        pos_d = pos_q + 4'd1;
        if (len_done) begin
          pos_d  = '0;
          aw_d   = '0;
          skip_d = len_val;
          if (pkt_tot_q != 4'd0) begin
            ii_d = ii_inc;
          end
          if (len_val != 16'd0) begin
            phase_nx = rvp_pkg::PH_SKIP;
          end else if (pkt_tot_q == 4'd0 || ii_inc >= pkt_tot_q) begin
            phase_nx = rvp_pkg::PH_TRAIL;
          end else begin
            phase_nx = rvp_pkg::PH_LEN;
          end
        end
      end
      rvp_pkg::PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          pos_d    = '0;
          aw_d     = '0;
          phase_nx = (pkt_tot_q == 4'd0 || ii_q >= pkt_tot_q) ?
                     rvp_pkg::PH_TRAIL : rvp_pkg::PH_LEN;
        end
      end
      rvp_pkg::PH_TRAIL: begin
        if (unused_q < CntMax) begin
          unused_d = unused_q + CntW'(1);
        end
      end
      default: begin
        phase_nx = rvp_pkg::PH_FIXED;
      end
    endcase
  end

  assign phase_d = eod ? rvp_pkg::PH_FIXED : phase_nx;

  // record outputs
  always_comb begin
    prec = '0;
    if (fixed_done) begin
      prec.record_kind    = rvp_pkg::KIND_RTP;
      prec.version        = ftb_q[15:14];
      prec.padding        = ftb_q[13];
      prec.extension      = ftb_q[12];
      prec.marker         = ftb_q[7];
      prec.payload_type   = ftb_q[6:0];
      prec.sequence_res   = seq_q;
      prec.word           = aw_sh;
      prec.count_or_index = ftb_q[11:8];
    end else if (word_done) begin
      prec.word = aw_sh;
      case (phase_q)
        rvp_pkg::PH_SSRC: prec.record_kind = rvp_pkg::KIND_SSRC;
        rvp_pkg::PH_CSRC: begin
          prec.record_kind    = rvp_pkg::KIND_CSRC;
          prec.count_or_index = ii_q;
        end
        default: begin
          prec.record_kind    = rvp_pkg::KIND_PAYHDR;
          prec.word           = {8'd0, aw_sh[31:8]};
          prec.frag_type      = b[7:6];
          prec.data_type      = b[5:4];
          prec.count_or_index = b[3:0];
        end
      endcase
    end else if (len_done) begin
      prec.word = {16'd0, len_val};
      if (pkt_tot_q == 4'd0) begin
        prec.record_kind = rvp_pkg::KIND_FRAGLEN;
      end else begin
        prec.record_kind    = rvp_pkg::KIND_BLKLEN;
        prec.count_or_index = ii_q;
      end
    end
    prec.last_of_run = !eod;
  end

  always_comb begin
    erec             = '0;
    erec.last_of_run = 1'b1;
    if (phase_nx == rvp_pkg::PH_TRAIL) begin
      erec.record_kind = rvp_pkg::KIND_END;
      erec.word        = {{(32-CntW){1'b0}}, unused_d};
    end else if (phase_nx == rvp_pkg::PH_SKIP) begin
      erec.record_kind = rvp_pkg::KIND_END;
    end else begin
      erec.record_kind = rvp_pkg::KIND_OVF;
    end
  end

  always_comb begin
    qwr_o.v0 = acc_i && (parse_rec || eod);
    qwr_o.v1 = acc_i && parse_rec && eod;
    qwr_o.r0 = parse_rec ? prec : erec;
    qwr_o.r1 = erec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rvp_pkg::PH_FIXED;
      pos_q      <= '0;
      aw_q       <= '0;
      ftb_q      <= '0;
      seq_q      <= '0;
      csrc_tot_q <= '0;
      ii_q       <= '0;
      pkt_tot_q  <= '0;
      skip_q     <= '0;
      unused_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      if (eod) begin
        pos_q      <= '0;
        aw_q       <= '0;
        ftb_q      <= '0;
        seq_q      <= '0;
        csrc_tot_q <= '0;
        ii_q       <= '0;
        pkt_tot_q  <= '0;
        skip_q     <= '0;
        unused_q   <= '0;
      end else begin
        pos_q      <= pos_d;
        aw_q       <= aw_d;
        ftb_q      <= ftb_d;
        seq_q      <= seq_d;
        csrc_tot_q <= csrc_tot_d;
        ii_q       <= ii_d;
        pkt_tot_q  <= pkt_tot_d;
        skip_q     <= skip_d;
        unused_q   <= unused_d;
      end
    end
  end

endmodule

// ----- sv/rvp_queue.sv -----
module rvp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rvp_pkg::qwr_t qwr_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output rvp_pkg::rec_t rec_o
);

  localparam int unsigned CntW = $clog2(rvp_pkg::QDepth + 1);

  rvp_pkg::rec_t                  mem_q [rvp_pkg::QDepth];
  logic [rvp_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rvp_pkg::QPtrW-1:0]      wr_ptr_1;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [CntW-1:0]                n_wr;
  logic                           rd_fire;

  assign empty_o  = (cnt_q == '0);
  // room for two records is kept so a byte can always land both
  assign full_o   = (cnt_q > CntW'(rvp_pkg::QDepth - 2));
  assign rec_o    = mem_q[rd_ptr_q];
  assign rd_fire  = pop_i && !empty_o;
  assign wr_ptr_1 = wr_ptr_q + rvp_pkg::QPtrW'(1);
  assign n_wr     = CntW'(qwr_i.v0) + CntW'(qwr_i.v1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_wr[rvp_pkg::QPtrW-1:0];
    rd_ptr_d = rd_ptr_q + rvp_pkg::QPtrW'(rd_fire);
    cnt_d    = cnt_q + n_wr - CntW'(rd_fire);
  end

  always_ff @(posedge clk_i) begin
    if (qwr_i.v0) begin
      mem_q[wr_ptr_q] <= qwr_i.r0;
    end
    if (qwr_i.v1) begin
      mem_q[wr_ptr_1] <= qwr_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
